// ===== rtl/pf_pkg.sv =====
// ----------------------------------------------------------------------------
// pf_pkg
// Shared types and constants of the Playfair digraph encryptor: grid
// geometry, letter codes, configuration register indexes and the digraph
// item that travels from the front part to the back part.
// ----------------------------------------------------------------------------
`default_nettype none

package pf_pkg;

  // Grid geometry.
  localparam int GridSide  = 5;
  localparam int GridCells = GridSide * GridSide;
  localparam int LetterW   = 5;
  localparam int CoordW    = $clog2(GridSide);
  localparam int CellIdxW  = $clog2(GridCells);

  // Data widths of the configuration registers.
  localparam int CfgDataW  = 60;
  localparam int CfgIndexW = 3;
  localparam int CellsPerWord = CfgDataW / LetterW;

  typedef logic [LetterW-1:0] letter_t;
  typedef logic [CoordW-1:0]  coord_t;
  typedef letter_t [GridCells-1:0] grid_t;

  // Filler letter x.
  localparam letter_t FillerCode = letter_t'(23);

  // Reset values of the merged pair (d and l).
  localparam letter_t MergeFirstReset  = letter_t'(3);
  localparam letter_t MergeSecondReset = letter_t'(11);

  // Configuration register indexes.
  localparam logic [CfgIndexW-1:0] CfgCellsA     = 3'd0;
  localparam logic [CfgIndexW-1:0] CfgCellsB     = 3'd1;
  localparam logic [CfgIndexW-1:0] CfgCellLast   = 3'd2;
  localparam logic [CfgIndexW-1:0] CfgMergeFirst = 3'd3;
  localparam logic [CfgIndexW-1:0] CfgMergeSecnd = 3'd4;

  // One digraph waiting for encryption.
  typedef struct packed {
    letter_t first;
    letter_t second;
    logic    last;
  } digraph_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

`default_nettype wire

// ===== rtl/pf_fifo.sv =====
// ----------------------------------------------------------------------------
// pf_fifo
// Short digraph queue between the front and the back part. One write and
// one read per cycle, status reported as a struct.
// ----------------------------------------------------------------------------
`default_nettype none

module pf_fifo #(
  parameter int DEPTH = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire pf_pkg::digraph_t push_data_i,
  input  wire logic             pop_i,
  output pf_pkg::digraph_t      pop_data_o,
  output pf_pkg::queue_stat_t   stat_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  pf_pkg::digraph_t mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  function automatic logic [PtrW-1:0] ptr_inc(logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    if (p == PtrW'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PtrW'(1);
    end
    return r;
  endfunction

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage, written at the tail.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign pop_data_o   = mem_q[rd_ptr_q];
  assign stat_o.full  = (count_q == CntW'(DEPTH));
  assign stat_o.empty = (count_q == '0);

endmodule

`default_nettype wire

// ===== rtl/pf_front.sv =====
// ----------------------------------------------------------------------------
// pf_front
// Accepts plaintext letters, applies the merge rule and pairs them into
// digraphs, splitting doubled letters and padding an odd final letter with
// the filler. Finished digraphs go into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module pf_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire pf_pkg::letter_t  in_letter_i,
  input  wire logic             in_eom_i,
  input  wire pf_pkg::letter_t  merge_first_i,
  input  wire pf_pkg::letter_t  merge_second_i,
  input  wire pf_pkg::queue_stat_t q_stat_i,
  output logic                  q_push_o,
  output pf_pkg::digraph_t      q_data_o
);

  logic             pend_valid_q, pend_valid_d;
  pf_pkg::letter_t  pend_letter_q, pend_letter_d;
  logic             extra_valid_q, extra_valid_d;
  pf_pkg::digraph_t extra_q, extra_d;

  pf_pkg::letter_t  letter_m;
  pf_pkg::letter_t  filler_m;
  logic             accept;
  logic             need_push;
  pf_pkg::digraph_t pair;

  function automatic pf_pkg::letter_t merge_letter(pf_pkg::letter_t code,
                                                   pf_pkg::letter_t first,
                                                   pf_pkg::letter_t second);
    return (code == second) ? first : code;
  endfunction

  assign letter_m   = merge_letter(in_letter_i, merge_first_i, merge_second_i);
  assign filler_m   = merge_letter(pf_pkg::FillerCode, merge_first_i, merge_second_i);
  assign in_ready_o = !extra_valid_q && !q_stat_i.full;
  assign accept     = in_valid_i && in_ready_o;

  // Pairing rules for one accepted letter.
  always_comb begin
    pend_valid_d  = pend_valid_q;
    pend_letter_d = pend_letter_q;
    extra_valid_d = extra_valid_q;
    extra_d       = extra_q;
    need_push     = 1'b0;
    pair          = '{first: pend_letter_q, second: letter_m, last: in_eom_i};

    if (accept) begin
      if (pend_valid_q) begin
        need_push = 1'b1;
        if (pend_letter_q == letter_m) begin
          // Doubled letter: close the held letter with the filler.
          pair = '{first: pend_letter_q, second: filler_m, last: 1'b0};
          if (in_eom_i) begin
            extra_valid_d = 1'b1;
            extra_d       = '{first: letter_m, second: filler_m, last: 1'b1};
            pend_valid_d  = 1'b0;
            pend_letter_d = '0;
          end else begin
            pend_letter_d = letter_m;
          end
        end else begin
          pend_valid_d  = 1'b0;
          pend_letter_d = '0;
        end
      end else if (in_eom_i) begin
        // Lone final letter is padded.
        need_push = 1'b1;
        pair      = '{first: letter_m, second: filler_m, last: 1'b1};
      end else begin
        pend_valid_d  = 1'b1;
        pend_letter_d = letter_m;
      end
    end else if (extra_valid_q && !q_stat_i.full) begin
      extra_valid_d = 1'b0;
    end
  end

  // Queue write: the held second digraph goes first when present.
  always_comb begin
    if (extra_valid_q) begin
      q_push_o = !q_stat_i.full;
      q_data_o = extra_q;
    end else begin
      q_push_o = need_push;
      q_data_o = pair;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q  <= 1'b0;
      pend_letter_q <= '0;
      extra_valid_q <= 1'b0;
    end else begin
      pend_valid_q  <= pend_valid_d;
      pend_letter_q <= pend_letter_d;
      extra_valid_q <= extra_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    extra_q <= extra_d;
  end

endmodule

`default_nettype wire

// ===== rtl/pf_back.sv =====
// ----------------------------------------------------------------------------
// pf_back
// Takes digraphs from the queue, locates both letters in the grid, applies
// the Playfair shift or swap and sends the two cipher letters out one per
// transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module pf_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire pf_pkg::grid_t       grid_i,
  input  wire pf_pkg::queue_stat_t q_stat_i,
  input  wire pf_pkg::digraph_t    q_data_i,
  output logic                     q_pop_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output pf_pkg::letter_t          out_letter_o,
  output logic                     out_last_o
);

  // Locate stage.
  logic           loc_valid_q, loc_valid_d;
  pf_pkg::coord_t ra_q, ca_q, rb_q, cb_q;
  logic           loc_last_q;
  pf_pkg::coord_t ra_d, ca_d, rb_d, cb_d;

  // Output stage.
  logic            out_valid_q, out_valid_d;
  logic            out_second_q, out_second_d;
  pf_pkg::letter_t code_a_q, code_b_q;
  pf_pkg::letter_t code_a_d, code_b_d;
  logic            out_last_q;

  logic           out_free;
  logic           loc_ready;
  logic           load_out;
  pf_pkg::coord_t na_r, na_c, nb_r, nb_c;

  // Highest matching cell wins; an absent letter sits at cell 0.
  function automatic void locate(pf_pkg::grid_t g, pf_pkg::letter_t code,
                                 output pf_pkg::coord_t row,
                                 output pf_pkg::coord_t col);
    row = '0;
    col = '0;
    for (int r = 0; r < pf_pkg::GridSide; r++) begin
      for (int c = 0; c < pf_pkg::GridSide; c++) begin
        if (g[r * pf_pkg::GridSide + c] == code) begin
          row = pf_pkg::coord_t'(r);
          col = pf_pkg::coord_t'(c);
        end
      end
    end
  endfunction

  function automatic pf_pkg::coord_t wrap_inc(pf_pkg::coord_t v);
    pf_pkg::coord_t r;
    if (v == pf_pkg::coord_t'(pf_pkg::GridSide - 1)) begin
      r = '0;
    end else begin
      r = v + pf_pkg::coord_t'(1);
    end
    return r;
  endfunction

  function automatic pf_pkg::letter_t cell_at(pf_pkg::grid_t g, pf_pkg::coord_t row,
                                              pf_pkg::coord_t col);
    logic [pf_pkg::CellIdxW-1:0] idx;
    idx = pf_pkg::CellIdxW'(row) * pf_pkg::CellIdxW'(pf_pkg::GridSide)
        + pf_pkg::CellIdxW'(col);
    return g[idx];
  endfunction

  // Handshake between the stages.
  assign out_free  = !out_valid_q || (out_ready_i && out_second_q);
  assign loc_ready = !loc_valid_q || out_free;
  assign load_out  = loc_valid_q && out_free;
  assign q_pop_o   = !q_stat_i.empty && loc_ready;

  // Position lookup of the digraph at the queue head.
  always_comb begin
    locate(grid_i, q_data_i.first, ra_d, ca_d);
    locate(grid_i, q_data_i.second, rb_d, cb_d);
    loc_valid_d = loc_valid_q;
    if (loc_ready) begin
      loc_valid_d = !q_stat_i.empty;
    end
  end

  // Playfair rule: same column, same row, or rectangle.
  always_comb begin
    na_r = ra_q;
    na_c = ca_q;
    nb_r = rb_q;
    nb_c = cb_q;
    if (ca_q == cb_q) begin
      na_r = wrap_inc(ra_q);
      nb_r = wrap_inc(rb_q);
    end else if (ra_q == rb_q) begin
      na_c = wrap_inc(ca_q);
      nb_c = wrap_inc(cb_q);
    end else begin
      na_c = cb_q;
      nb_c = ca_q;
    end
    code_a_d = cell_at(grid_i, na_r, na_c);
    code_b_d = cell_at(grid_i, nb_r, nb_c);
  end

  // Output register sequencing: first letter, then second letter.
  always_comb begin
    out_valid_d  = out_valid_q;
    out_second_d = out_second_q;
    if (load_out) begin
      out_valid_d  = 1'b1;
      out_second_d = 1'b0;
    end else if (out_valid_q && out_ready_i) begin
      if (out_second_q) begin
        out_valid_d = 1'b0;
      end
      out_second_d = !out_second_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loc_valid_q  <= 1'b0;
      out_valid_q  <= 1'b0;
      out_second_q <= 1'b0;
    end else begin
      loc_valid_q  <= loc_valid_d;
      out_valid_q  <= out_valid_d;
      out_second_q <= out_second_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      ra_q       <= ra_d;
      ca_q       <= ca_d;
      rb_q       <= rb_d;
      cb_q       <= cb_d;
      loc_last_q <= q_data_i.last;
    end
    if (load_out) begin
      code_a_q   <= code_a_d;
      code_b_q   <= code_b_d;
      out_last_q <= loc_last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_letter_o = out_second_q ? code_b_q : code_a_q;
  assign out_last_o   = out_second_q && out_last_q;

endmodule

`default_nettype wire

// ===== rtl/playfair_digraph_encrypt.sv =====
// ----------------------------------------------------------------------------
// playfair_digraph_encrypt
// Streaming Playfair encryptor: pairs plaintext letters into digraphs and
// emits two cipher letters per digraph from a 5x5 grid loaded by software.
//
//   Channel   Direction  Payload
//   s_axis    in         tdata[4:0] plain_letter, tlast end_of_message
//   m_axis    out        tdata[4:0] cipher_letter, tlast final_letter
//   cfg       in         cfg_index_i register, cfg_data_i value
//
// One letter is taken per cycle unless the queue is full or a held digraph
// waits; a cipher letter leaves per cycle while m_axis_tready is high. The back
// part sends both letters of a digraph from its output register. A doubled
// letter at the end of a message produces two digraphs, and the input then
// stalls while the second one enters the queue. A digraph passes the queue,
// the locate stage and the output register. Reset clears the held letter, the
// queue and the output. The config port is always ready, one write per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module playfair_digraph_encrypt #(
  parameter int FIFO_DEPTH = 4
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // tdata: [4:0] plain_letter, [7:5] zero
  input  wire logic [7:0]                    s_axis_tdata,
  input  wire logic                          s_axis_tlast,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata: [4:0] cipher_letter, [7:5] zero
  output logic [7:0]                         m_axis_tdata,
  output logic                               m_axis_tlast,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [pf_pkg::CfgIndexW-1:0]  cfg_index_i,
  input  wire logic [pf_pkg::CfgDataW-1:0]   cfg_data_i
);

  logic [pf_pkg::CfgDataW-1:0] cells_a_q;
  logic [pf_pkg::CfgDataW-1:0] cells_b_q;
  pf_pkg::letter_t             cell_last_q;
  pf_pkg::letter_t             merge_first_q;
  pf_pkg::letter_t             merge_second_q;
  pf_pkg::grid_t               grid;

  pf_pkg::queue_stat_t q_stat;
  logic                q_push, q_pop;
  pf_pkg::digraph_t    q_wdata, q_rdata;
  pf_pkg::letter_t     out_letter;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cells_a_q      <= '0;
      cells_b_q      <= '0;
      cell_last_q    <= '0;
      merge_first_q  <= pf_pkg::MergeFirstReset;
      merge_second_q <= pf_pkg::MergeSecondReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        pf_pkg::CfgCellsA:     cells_a_q      <= cfg_data_i;
        pf_pkg::CfgCellsB:     cells_b_q      <= cfg_data_i;
        pf_pkg::CfgCellLast:   cell_last_q    <= cfg_data_i[pf_pkg::LetterW-1:0];
        pf_pkg::CfgMergeFirst: merge_first_q  <= cfg_data_i[pf_pkg::LetterW-1:0];
        pf_pkg::CfgMergeSecnd: merge_second_q <= cfg_data_i[pf_pkg::LetterW-1:0];
        default: ;
      endcase
    end
  end

  // Grid view of the cell registers.
  always_comb begin
    for (int n = 0; n < pf_pkg::CellsPerWord; n++) begin
      grid[n]                        = cells_a_q[n*pf_pkg::LetterW +: pf_pkg::LetterW];
      grid[n + pf_pkg::CellsPerWord] = cells_b_q[n*pf_pkg::LetterW +: pf_pkg::LetterW];
    end
    grid[pf_pkg::GridCells-1] = cell_last_q;
  end

  pf_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .in_letter_i    (s_axis_tdata[pf_pkg::LetterW-1:0]),
    .in_eom_i       (s_axis_tlast),
    .merge_first_i  (merge_first_q),
    .merge_second_i (merge_second_q),
    .q_stat_i       (q_stat),
    .q_push_o       (q_push),
    .q_data_o       (q_wdata)
  );

  pf_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .pop_i       (q_pop),
    .pop_data_o  (q_rdata),
    .stat_o      (q_stat)
  );

  pf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .grid_i       (grid),
    .q_stat_i     (q_stat),
    .q_data_i     (q_rdata),
    .q_pop_o      (q_pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_letter_o (out_letter),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {3'b000, out_letter};

endmodule

`default_nettype wire

// ===== rtl/pf_props.sv =====
// ----------------------------------------------------------------------------
// pf_props
// Port-level properties of the Playfair encryptor, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pf_props (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic [7:0]  s_axis_tdata,
  input wire logic        s_axis_tlast,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [7:0]  m_axis_tdata,
  input wire logic        m_axis_tlast,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready
);

  logic out_odd_q;
  logic seen_in_q;

  // Letter parity of the output stream and first input seen since reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_odd_q <= 1'b0;
      seen_in_q <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        out_odd_q <= !out_odd_q;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        seen_in_q <= 1'b1;
      end
    end
  end

  // The final letter of a message always closes a digraph.
  a_last_on_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |-> out_odd_q)
    else $error("final letter sent on the first letter of a digraph");

  // No cipher letter before any plaintext transfer.
  a_no_output_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> seen_in_q)
    else $error("output valid before any input transfer");

  // Cipher letter codes use the low five bits only.
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[7:5] == 3'b000))
    else $error("padding bits of output data not zero");

  // A stalled output holds its letter.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("output changed while stalled");

  // Plaintext data fields are not used by these properties.
  logic unused_in;
  assign unused_in = ^{s_axis_tdata, s_axis_tlast};

endmodule

bind playfair_digraph_encrypt pf_props u_pf_props (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tlast  (s_axis_tlast),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);

`default_nettype wire
